// File: sv/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// vnorm_pkg
// Types and constants shared by the 2D vector normalization pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vnorm_pkg;

  localparam int IN_WIDTH      = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
  localparam int SQ_WIDTH      = 2 * IN_WIDTH;
  localparam int NUM_CELLS     = OUT_FRAC_BITS + 2;
  localparam int V_WIDTH       = OUT_FRAC_BITS + 2;
  localparam int SHIFT0        = 2 * OUT_FRAC_BITS + 2;
  localparam int R_WIDTH       = SQ_WIDTH + SHIFT0;
  localparam int W_WIDTH       = R_WIDTH + 2;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] vec_x;
    logic signed [IN_WIDTH-1:0] vec_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] unit_x;
    logic signed [OUT_WIDTH-1:0] unit_y;
    logic                        zero_length;
  } out_t;

  typedef struct packed {
    logic [R_WIDTH-1:0] r;
    logic [W_WIDTH-1:0] q;
    logic [V_WIDTH-1:0] v;
  } lane_t;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               neg_x;
    logic               neg_y;
    logic [W_WIDTH-1:0] b;
    lane_t              lx;
    lane_t              ly;
  } cell_t;

endpackage

`default_nettype wire

// File: sv/vnorm_front.sv
// ----------------------------------------------------------------------------
// vnorm_front
// Magnitudes, squares and squared length, feeding the first search cell.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire vnorm_pkg::in_t  in_data,
  output vnorm_pkg::cell_t     first
);
  import vnorm_pkg::*;

  logic                v1_r, v2_r, v3_r;
  logic                nx1_r, ny1_r, nx2_r, ny2_r, nx3_r, ny3_r;
  logic [IN_WIDTH-1:0] ax_r, ay_r;
  logic [SQ_WIDTH-1:0] ax2_r, ay2_r, sx_r, sy_r, s_r;
  logic [IN_WIDTH-1:0] ax_nxt, ay_nxt;

  always_comb begin
    ax_nxt = in_data.vec_x[IN_WIDTH-1] ? (~in_data.vec_x + 1'b1) : in_data.vec_x;
    ay_nxt = in_data.vec_y[IN_WIDTH-1] ? (~in_data.vec_y + 1'b1) : in_data.vec_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1_r <= in_data.vec_x[IN_WIDTH-1];
      ny1_r <= in_data.vec_y[IN_WIDTH-1];
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      nx2_r <= nx1_r;
      ny2_r <= ny1_r;
      ax2_r <= ax_r * ax_r;
      ay2_r <= ay_r * ay_r;
      nx3_r <= nx2_r;
      ny3_r <= ny2_r;
      sx_r  <= ax2_r;
      sy_r  <= ay2_r;
      s_r   <= ax2_r + ay2_r;
    end
  end

  always_comb begin
    first.valid = v3_r;
    first.zero  = (s_r == '0);
    first.neg_x = nx3_r;
    first.neg_y = ny3_r;
    first.b     = W_WIDTH'(s_r) << SHIFT0;
    first.lx.r  = R_WIDTH'(sx_r) << SHIFT0;
    first.lx.q  = '0;
    first.lx.v  = '0;
    first.ly.r  = R_WIDTH'(sy_r) << SHIFT0;
    first.ly.q  = '0;
    first.ly.v  = '0;
  end

endmodule

`default_nettype wire

// File: sv/vnorm_cell.sv
// ----------------------------------------------------------------------------
// vnorm_cell
// One bit of the square-root-style search, for both components at once.
// ----------------------------------------------------------------------------
`default_nettype none

module vnorm_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire vnorm_pkg::cell_t  cin,
  output vnorm_pkg::cell_t       cout
);
  import vnorm_pkg::*;

  cell_t cell_r, cell_nxt;

  function automatic lane_t lane_step(lane_t l, logic [W_WIDTH-1:0] b);
    logic [W_WIDTH-1:0] d;
    logic [W_WIDTH:0]   diff;
    logic [W_WIDTH-1:0] q2;
    logic               take;
    lane_t              o;
    d    = l.q + b;
    diff = {1'b0, W_WIDTH'(l.r)} - {1'b0, d};
    take = !diff[W_WIDTH];
    q2   = take ? (l.q + (b << 1)) : l.q;
    o.r  = take ? R_WIDTH'(diff) : l.r;
    o.q  = q2 >> 1;
    o.v  = {l.v[V_WIDTH-2:0], take};
    return o;
  endfunction

  always_comb begin
    cell_nxt    = cin;
    cell_nxt.b  = cin.b >> 2;
    cell_nxt.lx = lane_step(cin.lx, cin.b);
    cell_nxt.ly = lane_step(cin.ly, cin.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cout = cell_r;

endmodule

`default_nettype wire

// File: sv/vector2d_normalize.sv
// ----------------------------------------------------------------------------
// vector2d_normalize
// Unit vector of a signed 2D integer vector in rounded fixed point.
// ----------------------------------------------------------------------------
// Input transfers carry one vector (vec_x, vec_y); each gives exactly one
// result transfer with unit_x and unit_y in signed fixed point with
// OUT_FRAC_BITS fraction bits, rounded to nearest with ties away from zero.
// A zero vector raises zero_length and gives zero components.
// The pipeline has three stages for magnitudes, squares and squared
// length, one cell per result bit in the search chain, and the output
// register. Throughput is one vector per cycle while the receiver takes
// results; the chain of cells is fully pipelined.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// until the waiting result is taken.
// Reset clears all valid flags; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector2d_normalize (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire vnorm_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output vnorm_pkg::out_t       out_data
);
  import vnorm_pkg::*;

  logic  en;
  cell_t chain [NUM_CELLS+1];
  logic  out_valid_r;
  out_t  out_r, out_nxt;
  logic [V_WIDTH:0]   kx, ky;
  logic [OUT_WIDTH-1:0] mx, my;

  assign en = !out_valid_r || out_ready;

  vnorm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .first    (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    vnorm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .cin   (chain[i]),
      .cout  (chain[i+1])
    );
  end

  always_comb begin
    kx = ({1'b0, chain[NUM_CELLS].lx.v} + 1'b1) >> 1;
    ky = ({1'b0, chain[NUM_CELLS].ly.v} + 1'b1) >> 1;
    mx = OUT_WIDTH'(kx);
    my = OUT_WIDTH'(ky);
    out_nxt.unit_x      = chain[NUM_CELLS].neg_x ? (~mx + 1'b1) : mx;
    out_nxt.unit_y      = chain[NUM_CELLS].neg_y ? (~my + 1'b1) : my;
    out_nxt.zero_length = chain[NUM_CELLS].zero;
    if (chain[NUM_CELLS].zero) begin
      out_nxt.unit_x = '0;
      out_nxt.unit_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: bench/tb_vector2d_normalize.sv
// ----------------------------------------------------------------------------
// tb_vector2d_normalize
// Self-checking testbench for the 2D vector normalization pipeline.
// ----------------------------------------------------------------------------
// Directed vectors cover the field extremes, zero vectors, zero components
// and the axes; random vectors of mixed magnitude follow. A scoreboard
// predicts each rounded unit vector by an exact integer search and checks
// every result transfer in order. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vector2d_normalize;
  timeunit 1ns;
  timeprecision 1ps;

  import vnorm_pkg::*;

  class unit_vector_board;
    out_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Largest k in 0..2^F with (2*a*2^F)^2 >= (2k-1)^2 * s, s > 0.
    function logic [OUT_WIDTH-1:0] round_ratio(longint unsigned a, longint unsigned s);
      logic [127:0] lhs;
      logic [127:0] rhs;
      longint unsigned t;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned odd;
      t = (a << 1) << OUT_FRAC_BITS;
      lhs = 128'(t) * 128'(t);
      lo = 0;
      hi = 64'd1 << OUT_FRAC_BITS;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        odd = 2 * mid - 1;
        rhs = 128'(odd * odd) * 128'(s);
        if (lhs >= rhs) lo = mid;
        else hi = mid - 1;
      end
      return OUT_WIDTH'(lo);
    endfunction

    function void note_vector(in_t v);
      out_t e;
      longint signed x;
      longint signed y;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned s;
      logic [OUT_WIDTH-1:0] mx;
      logic [OUT_WIDTH-1:0] my;
      x = v.vec_x;
      y = v.vec_y;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      s = ax * ax + ay * ay;
      e = '0;
      if (s == 0) begin
        e.zero_length = 1'b1;
      end else begin
        mx = round_ratio(ax, s);
        my = round_ratio(ay, s);
        e.unit_x = (x < 0) ? -mx : mx;
        e.unit_y = (y < 0) ? -my : my;
      end
      pending.push_back(e);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.unit_x !== e.unit_x) begin
        $error("unit_x expected %0d actual %0d", e.unit_x, got.unit_x);
        errors++;
      end
      if (got.unit_y !== e.unit_y) begin
        $error("unit_y expected %0d actual %0d", e.unit_y, got.unit_y);
        errors++;
      end
      if (got.zero_length !== e.zero_length) begin
        $error("zero_length expected %0d actual %0d", e.zero_length, got.zero_length);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic stim_done = 1'b0;

  unit_vector_board board = new();

  vector2d_normalize dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [IN_WIDTH-1:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return {1'b1, {(IN_WIDTH-1){1'b0}}};
      2: return IN_WIDTH'(int'($urandom_range(0, 15)) - 8);
      3: return IN_WIDTH'(int'($urandom_range(0, 511)) - 256);
      default: return IN_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_vector(logic [IN_WIDTH-1:0] x, logic [IN_WIDTH-1:0] y, bit burst);
    int g;
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.vec_x <= x;
    in_data.vec_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_vector(in_data);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  initial begin
    int g;
    forever begin
      g = gap_len();
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    logic [IN_WIDTH-1:0] mn;
    logic [IN_WIDTH-1:0] mx;
    bit burst;
    mn = {1'b1, {(IN_WIDTH-1){1'b0}}};
    mx = {1'b0, {(IN_WIDTH-1){1'b1}}};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_vector('0, '0, 1'b0);
    send_vector(mn, mn, 1'b0);
    send_vector(mx, mx, 1'b0);
    send_vector(mn, mx, 1'b0);
    send_vector(mx, mn, 1'b0);
    send_vector(mn, '0, 1'b0);
    send_vector('0, mn, 1'b0);
    send_vector(mx, '0, 1'b0);
    send_vector('0, mx, 1'b0);
    send_vector(IN_WIDTH'(1), IN_WIDTH'(0), 1'b0);
    send_vector(IN_WIDTH'(0), IN_WIDTH'(-1), 1'b0);
    send_vector(IN_WIDTH'(-1), IN_WIDTH'(-1), 1'b0);
    send_vector(IN_WIDTH'(1), IN_WIDTH'(1), 1'b0);
    send_vector(IN_WIDTH'(3), IN_WIDTH'(4), 1'b0);
    send_vector(IN_WIDTH'(-3), IN_WIDTH'(4), 1'b0);
    send_vector(IN_WIDTH'(5), IN_WIDTH'(-12), 1'b0);
    send_vector(IN_WIDTH'(1), mn, 1'b0);
    send_vector(IN_WIDTH'(-1), mx, 1'b0);
    send_vector('0, '0, 1'b0);
    send_vector(16'h5555, 16'haaaa, 1'b0);
    send_vector(16'haaaa, 16'h5555, 1'b0);
    for (int i = 0; i < 400; i++) begin
      burst = (i % 100) >= 70;
      send_vector(rand_comp(), rand_comp(), burst);
    end
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_vector2d_normalize OK");
    end else begin
      $display("tb_vector2d_normalize NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_vector2d_normalize NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/vnorm_pkg.sv
sv/vnorm_front.sv
sv/vnorm_cell.sv
sv/vector2d_normalize.sv
bench/tb_vector2d_normalize.sv
